FILE: src/prq_pkg.sv
// shared types and constants of the priority run queue
`default_nettype none
package prq_pkg;

  localparam int unsigned TASK_SLOTS    = 16;
  localparam int unsigned TASK_ID_W     = 4;
  localparam int unsigned PRIO_W        = 8;
  localparam int unsigned SLICE_W       = 8;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned IN_DATA_W     = 16;
  localparam int unsigned OUT_DATA_W    = 16;
  localparam logic [SLICE_W-1:0] DEFAULT_SLICE = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREEMPT_ENABLE = 2'd1;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_PICK    = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_STEAL   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_POP_HEAD = 2'd2,
    OP_POP_TAIL = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic                 occ;
    logic [TASK_ID_W-1:0] id;
    logic [PRIO_W-1:0]    prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e             op;
    logic [TASK_ID_W-1:0] id;
    logic [PRIO_W-1:0]    prio;
    logic                 front;
  } cell_cmd_t;

  // write requests into the per-task table
  typedef struct packed {
    logic                 queued_we;
    logic [TASK_ID_W-1:0] queued_idx;
    logic                 queued_val;
    logic                 front_clr;
    logic [TASK_ID_W-1:0] front_clr_idx;
    logic                 front_set;
    logic [TASK_ID_W-1:0] front_set_idx;
    logic                 slice_we;
    logic [TASK_ID_W-1:0] slice_idx;
    logic [SLICE_W-1:0]   slice_val;
  } tbl_upd_t;

endpackage
`default_nettype wire

FILE: src/prq_cell.sv
// one slot of the sorted run queue chain
`default_nettype none
module prq_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire prq_pkg::cell_cmd_t cmd_i,
  input  wire prq_pkg::entry_t    left_i,
  input  wire logic               left_after_i,
  input  wire prq_pkg::entry_t    right_i,
  output prq_pkg::entry_t         ent_o,
  output logic                    after_o
);

  logic                          occ_q, occ_d;
  logic [prq_pkg::TASK_ID_W-1:0] id_q, id_d;
  logic [prq_pkg::PRIO_W-1:0]    prio_q, prio_d;
  logic                          after;

  always_comb begin
    after  = occ_q && (cmd_i.front ? (prio_q < cmd_i.prio) : (prio_q <= cmd_i.prio));
    occ_d  = occ_q;
    id_d   = id_q;
    prio_d = prio_q;
    unique case (cmd_i.op)
      prq_pkg::OP_INSERT: begin
        occ_d = occ_q | left_i.occ;
        if (!after) begin
          if (left_after_i) begin
            id_d   = cmd_i.id;
            prio_d = cmd_i.prio;
          end else begin
            id_d   = left_i.id;
            prio_d = left_i.prio;
          end
        end
      end
      prq_pkg::OP_POP_HEAD: begin
        occ_d  = right_i.occ;
        id_d   = right_i.id;
        prio_d = right_i.prio;
      end
      prq_pkg::OP_POP_TAIL: begin
        occ_d = occ_q & right_i.occ;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign ent_o   = '{occ: occ_q, id: id_q, prio: prio_q};
  assign after_o = after;

endmodule
`default_nettype wire

FILE: src/prq_task_tbl.sv
// per-task queued marks, front marks and slice counters
`default_nettype none
module prq_task_tbl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire prq_pkg::tbl_upd_t             upd_i,
  input  wire logic [prq_pkg::TASK_ID_W-1:0] id_i,
  input  wire logic [prq_pkg::TASK_ID_W-1:0] run_id_i,
  output logic                               queued_o,
  output logic                               front_o,
  output logic [prq_pkg::SLICE_W-1:0]        slice_o
);

  logic [prq_pkg::TASK_SLOTS-1:0] queued_q, queued_d;
  logic [prq_pkg::TASK_SLOTS-1:0] front_q, front_d;
  logic [prq_pkg::SLICE_W-1:0]    slice_q [prq_pkg::TASK_SLOTS];
  logic [prq_pkg::SLICE_W-1:0]    slice_d [prq_pkg::TASK_SLOTS];

  always_comb begin
    queued_d = queued_q;
    front_d  = front_q;
    slice_d  = slice_q;
    if (upd_i.queued_we) queued_d[upd_i.queued_idx] = upd_i.queued_val;
    if (upd_i.front_clr) front_d[upd_i.front_clr_idx] = 1'b0;
    // running task mark wins over clearing the enqueued one
    if (upd_i.front_set) front_d[upd_i.front_set_idx] = 1'b1;
    if (upd_i.slice_we) slice_d[upd_i.slice_idx] = upd_i.slice_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
      front_q  <= '0;
      for (int i = 0; i < prq_pkg::TASK_SLOTS; i++) slice_q[i] <= '0;
    end else begin
      queued_q <= queued_d;
      front_q  <= front_d;
      slice_q  <= slice_d;
    end
  end

  assign queued_o = queued_q[id_i];
  assign front_o  = front_q[id_i];
  assign slice_o  = slice_q[run_id_i];

endmodule
`default_nettype wire

FILE: src/priority_run_queue.sv
// top level of the priority run queue with time slice
// flow: an accepted word is held in the input stage and executed once the result
//   register is free or being drained; its result word is registered at execution
//   and valid from then on, and a stalled result word holds execution back
// the single input stage holds one word and takes no new word until that word has
//   been executed; the cell chain inserts or shifts as the word is executed
// reset: asynchronous active low, empties the queue, clears task marks and slices,
//   idle task running, slice_ticks 3 and preemption enabled
`default_nettype none
module priority_run_queue #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command words
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // task_id[3:0], task_prio[11:4], task_is_idle[12], was_preempted[13]
  input  wire logic [prq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]                     s_axis_tuser,
  // result words
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_valid[0], out_task_id[4:1], out_task_prio[12:5], resched_request[13]
  output logic [prq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // register writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [prq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [prq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDW = prq_pkg::TASK_ID_W;
  localparam int unsigned PW  = prq_pkg::PRIO_W;
  localparam int unsigned SW  = prq_pkg::SLICE_W;

  // configuration registers
  logic [SW-1:0] slice_ticks_q;
  logic          preempt_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_ticks_q <= prq_pkg::DEFAULT_SLICE;
      preempt_en_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        prq_pkg::REG_SLICE_TICKS:    slice_ticks_q <= cfg_data_i;
        prq_pkg::REG_PREEMPT_ENABLE: preempt_en_q  <= cfg_data_i[0];
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // input stage, holds one command word
  logic                 busy_q;
  prq_pkg::kind_e       kind_q;
  logic [IDW-1:0]       id_q;
  logic [PW-1:0]        prio_q;
  logic                 idle_q;
  logic                 preempted_q;

  // output register
  logic                 out_vld_q;
  logic [prq_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // running slot
  logic [IDW-1:0]       run_id_q, run_id_d;
  logic [PW-1:0]        run_prio_q, run_prio_d;
  logic                 run_busy_q, run_busy_d;

  logic fire;
  logic in_acc;

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && !busy_q;
  // execute once the result register is free or being drained
  assign fire          = busy_q && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q      <= prq_pkg::kind_e'(s_axis_tuser);
      id_q        <= s_axis_tdata[3:0];
      prio_q      <= s_axis_tdata[11:4];
      idle_q      <= s_axis_tdata[12];
      preempted_q <= s_axis_tdata[13];
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_id_q   <= '0;
      run_prio_q <= '0;
      run_busy_q <= 1'b0;
    end else begin
      run_id_q   <= run_id_d;
      run_prio_q <= run_prio_d;
      run_busy_q <= run_busy_d;
    end
  end

  // sorted chain of cells, head in cell zero
  prq_pkg::entry_t    ent     [MAX_TASKS];
  logic               after   [MAX_TASKS];
  prq_pkg::cell_cmd_t cell_cmd;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    prq_pkg::entry_t left_ent;
    prq_pkg::entry_t right_ent;
    logic            left_after;

    if (g == 0) begin : g_head
      // a new task lands here when nothing sorts ahead of it
      assign left_ent   = '{occ: 1'b1, id: '0, prio: '0};
      assign left_after = 1'b1;
    end else begin : g_inner
      assign left_ent   = ent[g-1];
      assign left_after = after[g-1];
    end

    if (g == MAX_TASKS - 1) begin : g_tail
      assign right_ent = '{occ: 1'b0, id: '0, prio: '0};
    end else begin : g_body
      assign right_ent = ent[g+1];
    end

    prq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cell_cmd),
      .left_i       (left_ent),
      .left_after_i (left_after),
      .right_i      (right_ent),
      .ent_o        (ent[g]),
      .after_o      (after[g])
    );
  end

  // tail is the last occupied cell, picked by a one-hot and-or
  logic [IDW-1:0] tail_id;
  logic [PW-1:0]  tail_prio;

  always_comb begin
    tail_id   = '0;
    tail_prio = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (ent[i].occ && ((i == MAX_TASKS - 1) || !ent[(i + 1) % MAX_TASKS].occ)) begin
        tail_id   = tail_id | ent[i].id;
        tail_prio = tail_prio | ent[i].prio;
      end
    end
  end

  // per-task table
  prq_pkg::tbl_upd_t tbl_upd;
  logic              tbl_queued;
  logic              tbl_front;
  logic [SW-1:0]     tbl_slice;

  prq_task_tbl u_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (tbl_upd),
    .id_i     (id_q),
    .run_id_i (run_id_q),
    .queued_o (tbl_queued),
    .front_o  (tbl_front),
    .slice_o  (tbl_slice)
  );

  // command execution
  logic          q_empty;
  logic          q_full;
  logic          enq_ok;
  logic          enq_preempt;
  logic          res_valid;
  logic [IDW-1:0] res_id;
  logic [PW-1:0]  res_prio;
  logic          res_resched;

  assign q_empty = !ent[0].occ;
  assign q_full  = ent[MAX_TASKS-1].occ;
  assign enq_ok  = !idle_q && !tbl_queued && !q_full;
  // preempt only a busy task with a larger priority value
  assign enq_preempt = enq_ok && !preempted_q && preempt_en_q && run_busy_q
                       && (prio_q < run_prio_q);

  always_comb begin
    cell_cmd    = '{op: prq_pkg::OP_HOLD, id: id_q, prio: prio_q, front: tbl_front};
    tbl_upd     = '0;
    run_id_d    = run_id_q;
    run_prio_d  = run_prio_q;
    run_busy_d  = run_busy_q;
    res_valid   = 1'b0;
    res_id      = '0;
    res_prio    = '0;
    res_resched = 1'b0;
    if (fire) begin
      unique case (kind_q)
        prq_pkg::KIND_ENQUEUE: begin
          if (enq_ok) begin
            cell_cmd.op           = prq_pkg::OP_INSERT;
            tbl_upd.queued_we     = 1'b1;
            tbl_upd.queued_idx    = id_q;
            tbl_upd.queued_val    = 1'b1;
            tbl_upd.front_clr     = 1'b1;
            tbl_upd.front_clr_idx = id_q;
            tbl_upd.slice_we      = 1'b1;
            tbl_upd.slice_idx     = id_q;
            tbl_upd.slice_val     = slice_ticks_q;
            tbl_upd.front_set     = enq_preempt;
            tbl_upd.front_set_idx = run_id_q;
            res_valid             = 1'b1;
            res_resched           = enq_preempt;
          end
        end
        prq_pkg::KIND_PICK: begin
          if (!q_empty) begin
            cell_cmd.op        = prq_pkg::OP_POP_HEAD;
            tbl_upd.queued_we  = 1'b1;
            tbl_upd.queued_idx = ent[0].id;
            tbl_upd.queued_val = 1'b0;
            run_id_d           = ent[0].id;
            run_prio_d         = ent[0].prio;
            run_busy_d         = 1'b1;
            res_valid          = 1'b1;
            res_id             = ent[0].id;
            res_prio           = ent[0].prio;
          end else begin
            run_busy_d = 1'b0;  // idle task takes the cpu
          end
        end
        prq_pkg::KIND_TICK: begin
          if (run_busy_q) begin
            // saturating decrement, expiry at or below one tick
            tbl_upd.slice_we  = 1'b1;
            tbl_upd.slice_idx = run_id_q;
            tbl_upd.slice_val = (tbl_slice == '0) ? '0 : tbl_slice - SW'(1);
            res_resched       = (tbl_slice <= SW'(1));
          end
        end
        prq_pkg::KIND_STEAL: begin
          if (!q_empty) begin
            cell_cmd.op        = prq_pkg::OP_POP_TAIL;
            tbl_upd.queued_we  = 1'b1;
            tbl_upd.queued_idx = tail_id;
            tbl_upd.queued_val = 1'b0;
            res_valid          = 1'b1;
            res_id             = tail_id;
            res_prio           = tail_prio;
          end
        end
        default: ;
      endcase
    end
    out_data_d = {2'b00, res_resched, res_prio, res_id, res_valid};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
